[rtl/core/msq_pkg.sv]
// Package: sizes, opcodes, status codes, item and control types for the stack/queue store.
package msq_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int QUEUE_DEPTH = 1024;
  localparam int STACK_COUNT = 33;

  localparam int OP_W   = 5;
  localparam int SN_W   = 6;
  localparam int WORD_W = 64;
  localparam int CNT_W  = 11;
  localparam int ST_W   = 2;

  localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
  localparam int SCELLS  = STACK_COUNT * STACK_DEPTH;
  localparam int SADDR_W = $clog2(SCELLS);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

  localparam logic [OP_W-1:0] OP_PUSH  = 5'd0;
  localparam logic [OP_W-1:0] OP_POP   = 5'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 5'd2;
  localparam logic [OP_W-1:0] OP_DUP   = 5'd3;
  localparam logic [OP_W-1:0] OP_LEN   = 5'd4;
  localparam logic [OP_W-1:0] OP_SEL   = 5'd5;
  localparam logic [OP_W-1:0] OP_SETB  = 5'd6;
  localparam logic [OP_W-1:0] OP_BPUSH = 5'd7;
  localparam logic [OP_W-1:0] OP_BPOP  = 5'd8;
  localparam logic [OP_W-1:0] OP_BPEEK = 5'd9;
  localparam logic [OP_W-1:0] OP_BLEN  = 5'd10;
  localparam logic [OP_W-1:0] OP_NPUSH = 5'd11;
  localparam logic [OP_W-1:0] OP_NPOP  = 5'd12;
  localparam logic [OP_W-1:0] OP_NPEEK = 5'd13;
  localparam logic [OP_W-1:0] OP_NLEN  = 5'd14;
  localparam logic [OP_W-1:0] OP_QON   = 5'd15;
  localparam logic [OP_W-1:0] OP_QOFF  = 5'd16;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [SN_W-1:0]          stack_no;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    logic [CNT_W-1:0]         fill_count;
    logic [ST_W-1:0]          status;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mem;
    logic load_out;
  } msq_cmd_t;

  typedef struct packed {
    logic need_mem;
  } msq_sts_t;

endpackage

[rtl/core/multi_stack_queue_store_unit.sv]
// Top level: stack bank and circular queue store with valid/ready channels.
//
//   beat    valid      ready      payload                           dir
//   input   in_valid   in_ready   in_data  (opcode, stack_no, value) in
//   result  out_valid  out_ready  out_data (word_out, fill_count, status) out
//
// One operation at a time: capture, execute (fill or pointer check, RAM access),
// RAM read return for pop/peek/dup, then load of the output register.
// An op without a word read skips the RAM read return phase; the fill RAM read
// followed by the stack RAM access sets this phase order.
// Sync active-low reset empties all stacks and the queue; no clearing pass.
// An unread result holds the next op in its last phase; later input beats wait.
module multi_stack_queue_store_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  msq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output msq_pkg::out_item_t out_data
);
  import msq_pkg::*;

  msq_cmd_t cmd;
  msq_sts_t sts;

  msq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

[rtl/core/msq_ram.sv]
// Generic simple dual-port RAM, one write and one registered read per cycle.
module msq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/msq_ctrl.sv]
// Controller: sequences capture, execute, memory and output phases of one operation.
module msq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  msq_pkg::msq_sts_t sts,
  output msq_pkg::msq_cmd_t cmd
);
  import msq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MEM  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_mem ? S_MEM : S_DONE;
      end
      S_MEM: begin
        cmd.mem   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/msq_dp.sv]
// Datapath: fill RAM, stack and queue RAMs, pointers, mode registers and result register.
module msq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  msq_pkg::in_item_t  in_data,
  input  msq_pkg::msq_cmd_t  cmd,
  output msq_pkg::msq_sts_t  sts,
  output msq_pkg::out_item_t out_data
);
  import msq_pkg::*;

  // captured operation
  logic [OP_W-1:0]    op_r;
  logic [SN_W-1:0]    sn_r;
  logic [WORD_W-1:0]  val_r;
  logic [SIDX_W-1:0]  tgt_idx_r;
  logic               tgt_ok_r;
  logic               fvalid_r;
  logic [SADDR_W-1:0] sbase_r;

  // architectural state
  logic [SIDX_W-1:0]      cur_r, cur_nxt;
  logic [SIDX_W-1:0]      base_r, base_nxt;
  logic                   qon_r, qon_nxt;
  logic [QPTR_W-1:0]      head_r, head_nxt;
  logic [QPTR_W-1:0]      tail_r, tail_nxt;
  logic [STACK_COUNT-1:0] valid_r, valid_nxt;

  // exec to mem
  logic               is_q_r;
  logic               dup_r;
  logic [SADDR_W-1:0] sdup_addr_r;
  logic [QPTR_W-1:0]  qdup_addr_r;

  // result
  logic [WORD_W-1:0] res_word_r;
  logic [CNT_W-1:0]  res_cnt_r;
  logic [ST_W-1:0]   res_st_r;
  out_item_t         out_r;

  // capture decode
  logic [SN_W-1:0]   tgt_sn;
  logic [SIDX_W-1:0] tgt_idx_c;
  logic              tgt_ok_c;

  // RAM ports
  logic [FILL_W-1:0]  fill_rdata;
  logic               fw_en;
  logic [FILL_W-1:0]  fw_data;
  logic               s_we, s_re;
  logic [SADDR_W-1:0] s_waddr, s_raddr;
  logic [WORD_W-1:0]  s_wdata, s_rdata;
  logic               q_we, q_re;
  logic [QPTR_W-1:0]  q_waddr, q_raddr;
  logic [WORD_W-1:0]  q_wdata, q_rdata;

  // exec
  logic [FILL_W-1:0] fill, fill_inc, fill_dec;
  logic              s_full, s_empty;
  logic [QPTR_W-1:0] tail_inc, head_inc, head_dec;
  logic              q_empty, q_full;
  logic [QPTR_W:0]   q_len;
  logic [ST_W-1:0]   st_c;
  logic [CNT_W-1:0]  cnt_c;
  logic              need_mem;

  always_comb begin
    case (in_data.opcode)
      OP_PUSH, OP_POP, OP_PEEK, OP_DUP, OP_LEN: tgt_sn = SN_W'(cur_r);
      OP_BPUSH, OP_BPOP, OP_BPEEK, OP_BLEN:     tgt_sn = SN_W'(base_r);
      default:                                  tgt_sn = in_data.stack_no;
    endcase
    tgt_ok_c  = int'(tgt_sn) < STACK_COUNT;
    tgt_idx_c = tgt_sn[SIDX_W-1:0];
  end

  assign fill     = fvalid_r ? fill_rdata : '0;
  assign fill_inc = fill + 1'b1;
  assign fill_dec = fill - 1'b1;
  assign s_full   = !tgt_ok_r || (int'(fill) >= STACK_DEPTH);
  assign s_empty  = !tgt_ok_r || (fill == '0);

  assign tail_inc = (int'(tail_r) == QUEUE_DEPTH - 1) ? '0 : tail_r + 1'b1;
  assign head_inc = (int'(head_r) == QUEUE_DEPTH - 1) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? QPTR_W'(QUEUE_DEPTH - 1) : head_r - 1'b1;
  assign q_empty  = (head_r == tail_r);
  assign q_full   = (tail_inc == head_r);
  assign q_len    = (tail_r >= head_r) ? ({1'b0, tail_r} - {1'b0, head_r})
                  : ({1'b0, tail_r} + (QPTR_W + 1)'(QUEUE_DEPTH) - {1'b0, head_r});

  always_comb begin
    logic q_sel;
    q_sel     = qon_r && (op_r <= OP_LEN);
    st_c      = ST_OK;
    cnt_c     = '0;
    need_mem  = 1'b0;
    fw_en     = 1'b0;
    fw_data   = fill_inc;
    s_we      = 1'b0;
    s_waddr   = sbase_r + SADDR_W'(fill);
    s_wdata   = val_r;
    s_re      = 1'b0;
    s_raddr   = sbase_r + SADDR_W'(fill_dec);
    q_we      = 1'b0;
    q_waddr   = tail_r;
    q_wdata   = val_r;
    q_re      = 1'b0;
    q_raddr   = head_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    base_nxt  = base_r;
    qon_nxt   = qon_r;
    valid_nxt = valid_r;
    if (cmd.exec) begin
      case (op_r)
        OP_PUSH, OP_BPUSH, OP_NPUSH: begin
          if (q_sel) begin
            if (q_full) begin
              st_c = ST_OVER;
            end else begin
              q_we     = 1'b1;
              tail_nxt = tail_inc;
            end
          end else if (s_full) begin
            st_c = ST_OVER;
          end else begin
            s_we  = 1'b1;
            fw_en = 1'b1;
          end
        end
        OP_POP, OP_PEEK, OP_BPOP, OP_BPEEK, OP_NPOP, OP_NPEEK: begin
          if (q_sel) begin
            if (q_empty) begin
              st_c = ST_UNDER;
            end else begin
              q_re     = 1'b1;
              need_mem = 1'b1;
              if (op_r == OP_POP) begin
                head_nxt = head_inc;
              end
            end
          end else if (s_empty) begin
            st_c = ST_UNDER;
          end else begin
            s_re     = 1'b1;
            need_mem = 1'b1;
            if (op_r == OP_POP || op_r == OP_BPOP || op_r == OP_NPOP) begin
              fw_en   = 1'b1;
              fw_data = fill_dec;
            end
          end
        end
        OP_DUP: begin
          if (q_sel) begin
            if (q_empty) begin
              st_c = ST_UNDER;
            end else if (q_full) begin
              st_c = ST_OVER;
            end else begin
              q_re     = 1'b1;
              need_mem = 1'b1;
              head_nxt = head_dec;
            end
          end else if (s_full) begin
            st_c = ST_OVER;
          end else if (s_empty) begin
            st_c = ST_UNDER;
          end else begin
            s_re     = 1'b1;
            need_mem = 1'b1;
            fw_en    = 1'b1;
          end
        end
        OP_LEN, OP_BLEN, OP_NLEN: begin
          cnt_c = q_sel ? CNT_W'(q_len) : CNT_W'(fill);
        end
        OP_SEL: begin
          if (int'(sn_r) < STACK_COUNT) begin
            cur_nxt = sn_r[SIDX_W-1:0];
          end
        end
        OP_SETB: base_nxt = cur_r;
        OP_QON:  qon_nxt  = 1'b1;
        OP_QOFF: qon_nxt  = 1'b0;
        default: ;
      endcase
      if (fw_en) begin
        valid_nxt[tgt_idx_r] = 1'b1;
      end
    end
    // duplicate: write the word just read
    if (cmd.mem && dup_r) begin
      if (is_q_r) begin
        q_we    = 1'b1;
        q_waddr = qdup_addr_r;
        q_wdata = q_rdata;
      end else begin
        s_we    = 1'b1;
        s_waddr = sdup_addr_r;
        s_wdata = s_rdata;
      end
    end
  end

  assign sts.need_mem = need_mem;

  msq_ram #(.WIDTH(FILL_W), .DEPTH(STACK_COUNT), .AW(SIDX_W)) u_fill_ram (
    .clk   (clk),
    .we    (fw_en),
    .waddr (tgt_idx_r),
    .wdata (fw_data),
    .re    (cmd.capture),
    .raddr (tgt_idx_c),
    .rdata (fill_rdata)
  );

  msq_ram #(.WIDTH(WORD_W), .DEPTH(SCELLS), .AW(SADDR_W)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  msq_ram #(.WIDTH(WORD_W), .DEPTH(QUEUE_DEPTH), .AW(QPTR_W)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      base_r  <= '0;
      qon_r   <= 1'b0;
      head_r  <= '0;
      tail_r  <= '0;
      valid_r <= '0;
    end else begin
      cur_r   <= cur_nxt;
      base_r  <= base_nxt;
      qon_r   <= qon_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_data.opcode;
      sn_r      <= in_data.stack_no;
      val_r     <= in_data.value;
      tgt_idx_r <= tgt_idx_c;
      tgt_ok_r  <= tgt_ok_c;
      fvalid_r  <= tgt_ok_c && valid_r[tgt_idx_c];
      sbase_r   <= SADDR_W'(int'(tgt_idx_c) * STACK_DEPTH);
    end
    if (cmd.exec) begin
      is_q_r      <= qon_r && (op_r <= OP_LEN);
      dup_r       <= (op_r == OP_DUP);
      sdup_addr_r <= sbase_r + SADDR_W'(fill);
      qdup_addr_r <= head_dec;
      res_word_r  <= '0;
      res_cnt_r   <= (st_c == ST_OK) ? cnt_c : '0;
      res_st_r    <= st_c;
    end
    if (cmd.mem) begin
      res_word_r <= is_q_r ? q_rdata : s_rdata;
    end
    if (cmd.load_out) begin
      out_r.word_out   <= res_word_r;
      out_r.fill_count <= res_cnt_r;
      out_r.status     <= res_st_r;
    end
  end

  assign out_data = out_r;

endmodule
